### src/smx_pkg.sv
package smx_pkg;

	// Word and field widths of the execute core.
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned CMD_W   = 4;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned FAULT_W = 2;

	// The program store size is a power of two, so a jump target is the low bits of the
	// immediate and an advancing pc wraps by plain overflow.
	localparam int unsigned PROG_DEPTH = 256;
	localparam int unsigned PC_W       = $clog2(PROG_DEPTH);

	localparam int unsigned STACK_DEPTH_DEF = 16;

	// Stream word widths, padded to whole bytes.
	localparam int unsigned IN_W  = ((CMD_W + DATA_W + 7) / 8) * 8;
	localparam int unsigned OUT_W = ((PC_W + DATA_W + COUNT_W + 1 + FAULT_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		OP_NOP  = 4'd0,
		OP_ADD  = 4'd1,
		OP_QUIT = 4'd2,
		OP_INC  = 4'd3,
		OP_DUP  = 4'd4,
		OP_SWAP = 4'd5,
		OP_PUSH = 4'd6,
		OP_JEQ  = 4'd7,
		OP_JMP  = 4'd8
	} opcode_t;

	typedef enum logic [FAULT_W-1:0] {
		FLT_NONE  = 2'd0,
		FLT_UNDER = 2'd1,
		FLT_OVER  = 2'd2,
		FLT_BADOP = 2'd3
	} fault_t;

endpackage

### src/stack_machine_execute_core.sv
// Stack machine execute core.
//
// The input stream carries one instruction per word: an opcode and a 32-bit
// immediate. An outside fetcher reads the program at the pc reported in the
// previous result word and sends that instruction here. The output stream
// carries one result word per instruction: next pc, top of stack (zero when
// the stack is empty), stack count, the sticky halt flag and a fault code.
// A faulting instruction changes no state, not even the pc; once QUIT has
// executed, every further instruction is ignored until reset.
//
// An accepted word is held in the instruction register and executed from there;
// its result word is then registered in the result register. Throughput is one
// instruction per cycle while the receiver does not stall: the stack is a row of
// shift cells with the top in a fixed place, so every operation is one pass
// of short logic with no memory read in the loop. When the receiver stalls,
// the result word holds, one more instruction waits in the instruction
// register, and then s_tready drops. Reset clears the pc, the stack count and
// the halt flag; stack cells are not cleared and are never read unwritten.
module stack_machine_execute_core #(
	parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// Fields from bit 0 up: command (4), immediate (32), zero padding (4).
	input  logic [smx_pkg::IN_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// Fields from bit 0 up: next_pc (8), top_value (32), stack_count (5),
	// halted (1), fault (2).
	output logic [smx_pkg::OUT_W-1:0] m_tdata
);

	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned DW    = smx_pkg::DATA_W;
	localparam int unsigned PW    = smx_pkg::PC_W;

	// Instruction register.
	logic                     valid_s1;
	logic [smx_pkg::CMD_W-1:0] cmd_s1;
	logic [DW-1:0]            imm_s1;

	// Architectural state. The stack is kept with its top in cell 0.
	logic [DW-1:0]    stk_q [STACK_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]    pc_q;
	logic             halt_q;

	// Next state and fault of the instruction being executed.
	logic [DW-1:0]          stk_d [STACK_DEPTH];
	logic [CNT_W-1:0]       cnt_d;
	logic [PW-1:0]          pc_d;
	logic                   halt_d;
	smx_pkg::fault_t        fault_d;
	logic [PW-1:0]          pc_inc;
	logic [PW-1:0]          pc_tgt;
	logic                   has_one;
	logic                   has_two;
	logic                   full;
	logic [DW-1:0]          top_d;

	// Result register.
	logic                     m_tvalid_q;
	logic [smx_pkg::OUT_W-1:0] m_tdata_q;

	logic accept;
	logic fire;

	// An instruction executes when the result register is empty or being drained.
	assign fire     = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign pc_inc  = pc_q + PW'(1);
	assign pc_tgt  = imm_s1[PW-1:0];
	assign has_one = cnt_q != '0;
	assign has_two = cnt_q >= CNT_W'(2);
	assign full    = cnt_q == CNT_W'(STACK_DEPTH);

	always_comb begin
		stk_d   = stk_q;
		cnt_d   = cnt_q;
		pc_d    = pc_q;
		halt_d  = halt_q;
		fault_d = smx_pkg::FLT_NONE;
		if (!halt_q) begin
			case (cmd_s1)
				smx_pkg::OP_NOP: begin
					pc_d = pc_inc;
				end
				smx_pkg::OP_ADD: begin
					if (!has_two) begin
						fault_d = smx_pkg::FLT_UNDER;
					end else begin
						stk_d[0] = stk_q[0] + stk_q[1];
						for (int i = 1; i < int'(STACK_DEPTH) - 1; i++) begin
							stk_d[i] = stk_q[i+1];
						end
						cnt_d = cnt_q - CNT_W'(1);
						pc_d  = pc_inc;
					end
				end
				smx_pkg::OP_QUIT: begin
					halt_d = 1'b1;
				end
				smx_pkg::OP_INC: begin
					if (!has_one) begin
						fault_d = smx_pkg::FLT_UNDER;
					end else begin
						stk_d[0] = stk_q[0] + DW'(1);
						pc_d     = pc_inc;
					end
				end
				smx_pkg::OP_DUP: begin
					if (!has_one) begin
						fault_d = smx_pkg::FLT_UNDER;
					end else if (full) begin
						fault_d = smx_pkg::FLT_OVER;
					end else begin
						for (int i = 1; i < int'(STACK_DEPTH); i++) begin
							stk_d[i] = stk_q[i-1];
						end
						cnt_d = cnt_q + CNT_W'(1);
						pc_d  = pc_inc;
					end
				end
				smx_pkg::OP_SWAP: begin
					if (!has_two) begin
						fault_d = smx_pkg::FLT_UNDER;
					end else begin
						stk_d[0] = stk_q[1];
						stk_d[1] = stk_q[0];
						pc_d     = pc_inc;
					end
				end
				smx_pkg::OP_PUSH: begin
					if (full) begin
						fault_d = smx_pkg::FLT_OVER;
					end else begin
						stk_d[0] = imm_s1;
						for (int i = 1; i < int'(STACK_DEPTH); i++) begin
							stk_d[i] = stk_q[i-1];
						end
						cnt_d = cnt_q + CNT_W'(1);
						pc_d  = pc_inc;
					end
				end
				smx_pkg::OP_JEQ: begin
					if (!has_two) begin
						fault_d = smx_pkg::FLT_UNDER;
					end else begin
						for (int i = 0; i < int'(STACK_DEPTH) - 2; i++) begin
							stk_d[i] = stk_q[i+2];
						end
						cnt_d = cnt_q - CNT_W'(2);
						pc_d  = (stk_q[0] == stk_q[1]) ? pc_tgt : pc_inc;
					end
				end
				smx_pkg::OP_JMP: begin
					pc_d = pc_tgt;
				end
				default: begin
					fault_d = smx_pkg::FLT_BADOP;
				end
			endcase
		end
	end

	assign top_d = (cnt_d != '0) ? stk_d[0] : '0;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
			cnt_q      <= '0;
			pc_q       <= '0;
			halt_q     <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				m_tvalid_q <= 1'b1;
				cnt_q      <= cnt_d;
				pc_q       <= pc_d;
				halt_q     <= halt_d;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload: instruction register, stack cells and result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= s_tdata[smx_pkg::CMD_W-1:0];
			imm_s1 <= s_tdata[smx_pkg::CMD_W +: DW];
		end
		if (fire) begin
			stk_q     <= stk_d;
			m_tdata_q <= smx_pkg::OUT_W'({fault_d, halt_d, smx_pkg::COUNT_W'(cnt_d), top_d, pc_d});
		end
	end

	// The stack count never passes the number of cells.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond stack depth");

	// Once halted, the core stays halted until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared without reset");

	// A faulting instruction leaves pc, count and halt flag as they were.
	a_fault_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (fault_d != smx_pkg::FLT_NONE) |=>
		cnt_q == $past(cnt_q) && pc_q == $past(pc_q) && halt_q == $past(halt_q))
		else $error("state changed on a faulting instruction");

	// Input back-pressure only while a word waits and the result is stalled.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid_q && !m_tready)
		else $error("input stalled without a stalled result");

	// An instruction ignored while halted reports no fault.
	a_halted_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		fire && halt_q |-> fault_d == smx_pkg::FLT_NONE)
		else $error("fault reported while halted");

endmodule
